>>> hdl/tbcf_pkg.sv
// ----------------------------------------------------------------------------
// tbcf_pkg: shared types, constants and helpers
// Payload structs, sequencer codes and the saturation and output rounding
// functions used by the two-band crossover core.
// ----------------------------------------------------------------------------
`default_nettype none

package tbcf_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int CHAN_W     = 3;
  localparam int GAIN_W     = 24;
  localparam int STATE_W    = 32;              // Q2.29 section state
  localparam int DIFF_W     = STATE_W + 1;     // u - s
  localparam int Y_W        = STATE_W + 2;     // scaled difference
  localparam int SUM_W      = STATE_W + 3;     // state plus scaled difference
  localparam int DIGIT_W    = 4;               // gain bits consumed per cycle
  localparam int MUL_STEPS  = GAIN_W / DIGIT_W;
  localparam int STEP_CNT_W = $clog2(MUL_STEPS);
  localparam int ACC_W      = DIFF_W + DIGIT_W + 1;
  localparam int ROUND_STEP = (GAIN_W - 1) / DIGIT_W;
  // 29 fraction bits of state against 23 of a sample
  localparam int FRAC_SHIFT = (STATE_W - 3) - (SAMPLE_W - 1);

  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd1031800;
  localparam logic [ACC_W-1:0] ROUND_ADD = ACC_W'(1 << ((GAIN_W - 1) % DIGIT_W));

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [CHAN_W-1:0]          channel_index;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] low_out;
    logic signed [SAMPLE_W-1:0] high_out;
  } out_item_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIFF_W-1:0] diff;
  } mul_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [Y_W-1:0] y;
  } mul_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_ADD1,
    S_ADD2,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    SEC_LP1,
    SEC_LP2,
    SEC_HP
  } sect_t;

  // clamp to the 32-bit signed range
  function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-STATE_W:0] top;
    top = v[SUM_W-1:STATE_W-1];
    if (top == '0 || top == '1) begin
      return v[STATE_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

  // Q2.29 to Q0.23, round half up, clamp to 24 bits
  function automatic logic signed [SAMPLE_W-1:0] to_out(input logic signed [STATE_W-1:0] v);
    logic signed [STATE_W:0]     r;
    logic signed [STATE_W:0]     t;
    logic [STATE_W-SAMPLE_W+1:0] top;
    r   = (STATE_W+1)'(v) + (STATE_W+1)'(1 << (FRAC_SHIFT - 1));
    t   = r >>> FRAC_SHIFT;
    top = t[STATE_W:SAMPLE_W-1];
    if (top == '0 || top == '1) begin
      return t[SAMPLE_W-1:0];
    end else if (t[STATE_W]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

>>> hdl/tbcf_ram.sv
// ----------------------------------------------------------------------------
// tbcf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tbcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/tbcf_serial_mul.sv
// ----------------------------------------------------------------------------
// tbcf_serial_mul: digit-serial scaled multiply
// Computes floor((diff * g + 2^23) / 2^24), four gain bits per cycle, LSB
// digit first, shifting the partial sum right as it goes.
// ----------------------------------------------------------------------------
`default_nettype none

module tbcf_serial_mul (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [tbcf_pkg::GAIN_W-1:0]  gain,
  input  wire tbcf_pkg::mul_req_t           req,
  output tbcf_pkg::mul_res_t                res
);

  logic                                   busy;
  logic                                   done;
  logic [tbcf_pkg::STEP_CNT_W-1:0]        cnt;
  logic [tbcf_pkg::GAIN_W-1:0]            gsh;
  logic signed [tbcf_pkg::DIFF_W-1:0]     diff;
  logic signed [tbcf_pkg::ACC_W-1:0]      acc;
  logic signed [tbcf_pkg::ACC_W-1:0]      prod;
  logic signed [tbcf_pkg::ACC_W-1:0]      sum;
  logic [tbcf_pkg::ACC_W-1:0]             rnd;
  logic                                   last;

  assign last = (cnt == tbcf_pkg::STEP_CNT_W'(tbcf_pkg::MUL_STEPS - 1));

  always_comb begin
    prod = tbcf_pkg::ACC_W'(diff)
         * tbcf_pkg::ACC_W'($signed({1'b0, gsh[tbcf_pkg::DIGIT_W-1:0]}));
    // rounding half-LSB lands in the digit holding gain bit 23
    rnd  = (cnt == tbcf_pkg::STEP_CNT_W'(tbcf_pkg::ROUND_STEP)) ? tbcf_pkg::ROUND_ADD : '0;
    sum  = acc + prod + rnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc  <= '0;
      gsh  <= gain;
      diff <= req.diff;
    end else if (busy) begin
      acc <= sum >>> tbcf_pkg::DIGIT_W;
      gsh <= gsh >> tbcf_pkg::DIGIT_W;
    end
  end

  assign res.done = done;
  assign res.y    = acc[tbcf_pkg::Y_W-1:0];

endmodule

`default_nettype wire

>>> hdl/two_band_crossover_filter_core.sv
// ----------------------------------------------------------------------------
// two_band_crossover_filter_core: two-band crossover, one-pole TPT sections
// Splits each sample into a low band (lowpass twice) and an inverted-polarity
// high band (highpass twice), with per-channel state held in RAM.
// ----------------------------------------------------------------------------
// One transaction occupies the core from acceptance until its result is taken
// (a channel number at or above CHANNELS goes straight to the finish state,
// returns zeros and leaves all state alone). This is set by the shared 4-bit
// digit-serial multiplier: each of the three sections takes six digit steps, a
// hand-off and the state updates S_ADD1 and S_ADD2, and the sections run one
// after another on the single multiplier. A finished result sits in the output
// register while the next transaction is accepted. The gain register may only
// be written while the core is idle; the per-channel state is cleared by reset
// through valid bits, so no clearing pass is needed.
`default_nettype none

module two_band_crossover_filter_core #(
  parameter int CHANNELS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire tbcf_pkg::in_item_t            in_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output tbcf_pkg::out_item_t                out_item,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tbcf_pkg::GAIN_W-1:0]   cfg_data
);

  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RAM_W = 3 * tbcf_pkg::STATE_W;
  localparam int SW    = tbcf_pkg::STATE_W;

  tbcf_pkg::state_t state, state_next;
  tbcf_pkg::sect_t  sect;

  logic [tbcf_pkg::GAIN_W-1:0] gain;

  logic                  in_fire;
  logic                  fin_fire;
  logic                  ch_ok;
  logic                  in_range;
  logic                  vld_rd;
  logic [CHANNELS-1:0]   vld;
  logic [AW-1:0]         addr;
  logic [AW-1:0]         in_addr;
  logic                  ram_we;
  logic [RAM_W-1:0]      ram_rdata;

  logic signed [SW-1:0]  u;
  logic signed [SW-1:0]  s1, s2, s3;
  logic signed [SW-1:0]  rd_s1, rd_s2, rd_s3;
  logic signed [SW-1:0]  s_cur;
  logic signed [SW-1:0]  s_new;
  logic signed [SW-1:0]  xreg;
  logic signed [SW-1:0]  hp1;
  logic signed [SW-1:0]  low;
  logic signed [SW-1:0]  high;

  tbcf_pkg::mul_req_t mul_req;
  tbcf_pkg::mul_res_t mul_res;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= tbcf_pkg::GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain <= cfg_data;
    end
  end

  assign in_fire  = in_valid && in_ready;
  assign ch_ok    = (32'(in_item.channel_index) < 32'(CHANNELS));
  assign in_addr  = AW'(in_item.channel_index);
  assign fin_fire = (state == tbcf_pkg::S_FIN) && (!out_valid || out_ready);
  assign ram_we   = fin_fire && in_range;

  tbcf_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata ({s1, s2, s3}),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // a channel never written reads as zero state
  assign rd_s1 = vld_rd ? ram_rdata[3*SW-1:2*SW] : '0;
  assign rd_s2 = vld_rd ? ram_rdata[2*SW-1:SW]   : '0;
  assign rd_s3 = vld_rd ? ram_rdata[SW-1:0]      : '0;

  tbcf_serial_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .gain (gain),
    .req  (mul_req),
    .res  (mul_res)
  );

  always_comb begin
    case (sect)
      tbcf_pkg::SEC_LP1: s_cur = s1;
      tbcf_pkg::SEC_LP2: s_cur = s2;
      default:           s_cur = s3;
    endcase
    s_new = tbcf_pkg::sat_state(tbcf_pkg::SUM_W'(xreg) + tbcf_pkg::SUM_W'(mul_res.y));
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbcf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    mul_req.start = 1'b0;
    mul_req.diff  = '0;
    unique case (state)
      tbcf_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ch_ok ? tbcf_pkg::S_READ : tbcf_pkg::S_FIN;
        end
      end
      tbcf_pkg::S_READ: begin
        mul_req.start = 1'b1;
        mul_req.diff  = tbcf_pkg::DIFF_W'(u) - tbcf_pkg::DIFF_W'(rd_s1);
        state_next    = tbcf_pkg::S_MUL;
      end
      tbcf_pkg::S_MUL: begin
        if (mul_res.done) begin
          state_next = tbcf_pkg::S_ADD1;
        end
      end
      tbcf_pkg::S_ADD1: begin
        state_next = tbcf_pkg::S_ADD2;
      end
      tbcf_pkg::S_ADD2: begin
        if (sect == tbcf_pkg::SEC_LP1) begin
          // low band path: second lowpass fed by the first lowpass
          mul_req.start = 1'b1;
          mul_req.diff  = tbcf_pkg::DIFF_W'(xreg) - tbcf_pkg::DIFF_W'(s2);
          state_next    = tbcf_pkg::S_MUL;
        end else if (sect == tbcf_pkg::SEC_LP2) begin
          mul_req.start = 1'b1;
          mul_req.diff  = tbcf_pkg::DIFF_W'(hp1) - tbcf_pkg::DIFF_W'(s3);
          state_next    = tbcf_pkg::S_MUL;
        end else begin
          state_next = tbcf_pkg::S_FIN;
        end
      end
      tbcf_pkg::S_FIN: begin
        if (!out_valid || out_ready) begin
          state_next = tbcf_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tbcf_pkg::S_IDLE;
      end
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      u        <= {{(SW - tbcf_pkg::SAMPLE_W - tbcf_pkg::FRAC_SHIFT)
                    {in_item.sample_in[tbcf_pkg::SAMPLE_W-1]}},
                   in_item.sample_in,
                   {tbcf_pkg::FRAC_SHIFT{1'b0}}};
      addr     <= in_addr;
      in_range <= ch_ok;
      vld_rd   <= ch_ok && vld[in_addr];
    end
    if (state == tbcf_pkg::S_READ) begin
      s1   <= rd_s1;
      s2   <= rd_s2;
      s3   <= rd_s3;
      sect <= tbcf_pkg::SEC_LP1;
    end
    if (state == tbcf_pkg::S_ADD1) begin
      xreg <= tbcf_pkg::sat_state(tbcf_pkg::SUM_W'(s_cur) + tbcf_pkg::SUM_W'(mul_res.y));
    end
    if (state == tbcf_pkg::S_ADD2) begin
      case (sect)
        tbcf_pkg::SEC_LP1: begin
          s1   <= s_new;
          hp1  <= tbcf_pkg::sat_state(tbcf_pkg::SUM_W'(u) - tbcf_pkg::SUM_W'(xreg));
          sect <= tbcf_pkg::SEC_LP2;
        end
        tbcf_pkg::SEC_LP2: begin
          s2   <= s_new;
          low  <= xreg;
          sect <= tbcf_pkg::SEC_HP;
        end
        default: begin
          s3   <= s_new;
          // high band is lowpass of hp1 minus hp1: inverted double highpass
          high <= tbcf_pkg::sat_state(tbcf_pkg::SUM_W'(xreg) - tbcf_pkg::SUM_W'(hp1));
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ram_we) begin
      vld[addr] <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_item.low_out  <= in_range ? tbcf_pkg::to_out(low)  : '0;
      out_item.high_out <= in_range ? tbcf_pkg::to_out(high) : '0;
    end
  end

`ifndef SYNTH
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == tbcf_pkg::S_FIN))
    else $error("result presented without a finished transaction");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == tbcf_pkg::S_READ || state == tbcf_pkg::S_FIN))
    else $error("accepted transaction did not start processing");

  a_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mul_res.done |-> state == tbcf_pkg::S_MUL)
    else $error("multiplier finished outside its wait state");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (in_range && state == tbcf_pkg::S_FIN && sect == tbcf_pkg::SEC_HP))
    else $error("state written for a channel that was not filtered");
`endif

endmodule

`default_nettype wire
